// ----- hw/rtl/dap_pkg.sv -----
// ----------------------------------------------------------------------------
// dap_pkg
// Shared constants for the dipole angle restraint force pipeline.
// ----------------------------------------------------------------------------
package dap_pkg;

	// restraint types and configuration port
	localparam int NUM_TYPES = 4;
	localparam int TYPE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 31;

	// register indexes: force constants first, then rest cosines
	localparam logic [CFG_IDX_W-1:0] CFG_K_TYPE0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CREST_TYPE0 = 3'd4;

	// rest cosine after reset is 1.0
	localparam logic signed [17:0] CREST_RESET = 18'sd65536;

	// latencies of the arithmetic units
	localparam int MUL_LAT  = 2;
	localparam int SQRT_LAT = 33;
	localparam int DIV_LAT  = 64;

endpackage

// ----- hw/rtl/dap_mul64.sv -----
// ----------------------------------------------------------------------------
// dap_mul64
// Unsigned 64x64 multiplier, four 32x32 partial products, two stages.
// ----------------------------------------------------------------------------
module dap_mul64 (
	input  logic         clk,
	input  logic         en,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] p
);

	logic [63:0]  pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic [127:0] p_s2;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			pp01_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			pp10_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			pp11_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= {64'd0, pp00_s1} + {32'd0, pp01_s1, 32'd0}
				+ {32'd0, pp10_s1, 32'd0} + {pp11_s1, 64'd0};
		end
	end

	assign p = p_s2;

endmodule

// ----- hw/rtl/dap_isqrt.sv -----
// ----------------------------------------------------------------------------
// dap_isqrt
// Pipelined integer square root of a 66-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module dap_isqrt import dap_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [65:0] v,
	output logic [32:0] root
);

	localparam int STEPS = SQRT_LAT;

	logic [34:0] rem_s  [STEPS];
	logic [32:0] root_s [STEPS];
	logic [65:0] val_s  [STEPS-1];
	logic [34:0] rem_in  [STEPS];
	logic [32:0] root_in [STEPS];
	logic [65:0] val_in  [STEPS];

	// stage inputs
	always_comb begin
		rem_in[0]  = '0;
		root_in[0] = '0;
		val_in[0]  = v;
		for (int i = 1; i < STEPS; i++) begin
			rem_in[i]  = rem_s[i-1];
			root_in[i] = root_s[i-1];
			val_in[i]  = val_s[i-1];
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic [36:0] ext;
		logic [36:0] trial;

		// bring down the next bit pair and try root*4+1
		assign ext   = {rem_in[g], val_in[g][2*(STEPS-1-g)+1 -: 2]};
		assign trial = {2'b00, root_in[g], 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (ext >= trial) begin
					rem_s[g]  <= 35'(ext - trial);
					root_s[g] <= {root_in[g][31:0], 1'b1};
				end else begin
					rem_s[g]  <= ext[34:0];
					root_s[g] <= {root_in[g][31:0], 1'b0};
				end
			end
		end

		if (g < STEPS-1) begin : g_val
			always_ff @(posedge clk) begin
				if (en) begin
					val_s[g] <= val_in[g];
				end
			end
		end
	end

	assign root = root_s[STEPS-1];

endmodule

// ----- hw/rtl/dap_div.sv -----
// ----------------------------------------------------------------------------
// dap_div
// Pipelined restoring divider: 128-bit dividend, 66-bit divisor, 64 quotient
// bits, one per stage, with a flag for quotients that need more than 64 bits.
// ----------------------------------------------------------------------------
module dap_div import dap_pkg::*; (
	input  logic         clk,
	input  logic         en,
	input  logic [127:0] n,
	input  logic [65:0]  d,
	output logic [63:0]  q,
	output logic         ovf
);

	localparam int STEPS = DIV_LAT;

	logic [65:0] rem_s [STEPS-1];
	logic [63:0] lo_s  [STEPS-1];
	logic [65:0] d_s   [STEPS-1];
	logic [63:0] q_s   [STEPS];
	logic        ovf_s [STEPS];
	logic [65:0] rem_in [STEPS];
	logic [63:0] lo_in  [STEPS];
	logic [65:0] d_in   [STEPS];
	logic [63:0] q_in   [STEPS];
	logic        ovf_in [STEPS];

	// stage inputs; upper half not below the divisor means too wide a quotient
	always_comb begin
		rem_in[0] = {2'b00, n[127:64]};
		lo_in[0]  = n[63:0];
		d_in[0]   = d;
		q_in[0]   = '0;
		ovf_in[0] = ({2'b00, n[127:64]} >= d);
		for (int i = 1; i < STEPS; i++) begin
			rem_in[i] = rem_s[i-1];
			lo_in[i]  = lo_s[i-1];
			d_in[i]   = d_s[i-1];
			q_in[i]   = q_s[i-1];
			ovf_in[i] = ovf_s[i-1];
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic [66:0] ext;
		logic        take;

		assign ext  = {rem_in[g], lo_in[g][63]};
		assign take = (ext >= {1'b0, d_in[g]});

		// quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[g]   <= {q_in[g][62:0], take};
				ovf_s[g] <= ovf_in[g];
			end
		end

		// partial remainder for the next stage
		if (g < STEPS-1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= take ? 66'(ext - {1'b0, d_in[g]}) : ext[65:0];
					lo_s[g]  <= {lo_in[g][62:0], 1'b0};
					d_s[g]   <= d_in[g];
				end
			end
		end
	end

	assign q   = q_s[STEPS-1];
	assign ovf = ovf_s[STEPS-1];

endmodule

// ----- hw/rtl/dipole_angle_restraint_force.sv -----
// ----------------------------------------------------------------------------
// dipole_angle_restraint_force
// Dipole orientation restraint: energy, torque on the dipole and the force
// couple on the reference and dipole atoms, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// The block takes one restraint word per clock while in_stall is low and
// returns one result word per input word, in order, from the last of its
// 241 register stages. The depth is set by the three chained 64-stage
// restoring dividers (cosine, torque, force) and the 33-stage square root
// for the distance. A stall on the output freezes every stage at once, so
// in_stall follows out_stall while a result waits. Configuration registers
// are read as items pass; the user must write them only while the pipeline
// is empty, and the block itself does not enforce this.
module dipole_angle_restraint_force import dap_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   ref_x,
	input  logic signed [31:0]   ref_y,
	input  logic signed [31:0]   ref_z,
	input  logic signed [31:0]   dip_x,
	input  logic signed [31:0]   dip_y,
	input  logic signed [31:0]   dip_z,
	input  logic signed [31:0]   mu_x,
	input  logic signed [31:0]   mu_y,
	input  logic signed [31:0]   mu_z,
	input  logic [30:0]          mu_mag,
	input  logic [TYPE_W-1:0]    type_index,
	input  logic                 want_energy,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   torque_x,
	output logic signed [31:0]   torque_y,
	output logic signed [31:0]   torque_z,
	output logic signed [31:0]   force_x,
	output logic signed [31:0]   force_y,
	output logic signed [31:0]   force_z,
	output logic [30:0]          energy,
	output logic                 status
);

	// stage times
	localparam int T_IN  = 1;
	localparam int T_P   = T_IN + MUL_LAT;
	localparam int T_SUM = T_P + 1;
	localparam int T_R   = T_SUM + SQRT_LAT;
	localparam int T_RMU = T_R + MUL_LAT;
	localparam int T_COS = T_RMU + DIV_LAT;
	localparam int T_DG  = T_COS + 1;
	localparam int T_KM  = T_DG + MUL_LAT;
	localparam int T_TN  = T_KM + MUL_LAT;
	localparam int T_TQ  = T_TN + DIV_LAT;
	localparam int T_T   = T_TQ + 1;
	localparam int T_FP  = T_T + MUL_LAT;
	localparam int T_FN  = T_FP + 1;
	localparam int T_FQ  = T_FN + DIV_LAT;
	localparam int T_OUT = T_FQ + 1;

	// delay line lengths
	localparam int L_MM  = T_R - T_IN;
	localparam int L_DOT = T_RMU - T_SUM;
	localparam int L_TYP = T_COS - T_IN;
	localparam int L_C   = T_KM - T_SUM;
	localparam int L_TNG = T_TQ - T_KM;
	localparam int L_WE  = T_TN - T_IN;
	localparam int L_EN  = T_FQ - T_TN;
	localparam int L_RMU = T_TN - T_RMU;
	localparam int L_D   = T_T - T_IN;
	localparam int L_R2  = T_FN - T_SUM;
	localparam int L_TC  = T_FQ - T_T;
	localparam int L_DEG = T_FQ - T_RMU;

	// operand selection of the geometry products
	localparam int NPG = 12;
	localparam int OPA [NPG] = '{0, 1, 2, 0, 1, 2, 1, 2, 2, 0, 0, 1};
	localparam int OPB [NPG] = '{0, 1, 2, 0, 1, 2, 2, 1, 0, 2, 1, 0};
	// operand selection of the force products
	localparam int NPF = 6;
	localparam int FDA [NPF] = '{1, 2, 2, 0, 0, 1};
	localparam int FTB [NPF] = '{2, 1, 0, 2, 1, 0};

	function automatic logic [63:0] mag33(input logic signed [32:0] v);
		logic [32:0] u;
		u = $unsigned(v);
		return {31'd0, v[32] ? (~u + 33'd1) : u};
	endfunction

	function automatic logic [31:0] sat32(input logic neg, input logic big,
		input logic [63:0] mag);
		logic over;
		over = big || (mag[63:31] != '0);
		if (!neg) return over ? 32'h7FFF_FFFF : mag[31:0];
		else return over ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
	endfunction

	function automatic logic [31:0] clamp32(input logic signed [63:0] t);
		if (!t[63] && (t[62:31] != '0)) return 32'h7FFF_FFFF;
		else if (t[63] && (t[62:31] != '1)) return 32'h8000_0000;
		else return t[31:0];
	endfunction

	// configuration registers
	logic [30:0]        k_q     [NUM_TYPES];
	logic signed [17:0] crest_q [NUM_TYPES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TYPES; i++) begin
				k_q[i]     <= '0;
				crest_q[i] <= CREST_RESET;
			end
		end else if (cfg_we) begin
			if (cfg_index < CFG_CREST_TYPE0) begin
				k_q[cfg_index[TYPE_W-1:0] - CFG_K_TYPE0[TYPE_W-1:0]] <= cfg_data;
			end else begin
				crest_q[cfg_index[TYPE_W-1:0]] <= cfg_data[17:0];
			end
		end
	end

	// global advance and valid tracking
	logic             en;
	logic [T_OUT-1:0] vld_s;

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_s[T_OUT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[T_OUT-2:0], in_valid};
		end
	end

	// input stage: separation vector and item fields
	logic signed [32:0]  d_s1 [3];
	logic signed [31:0]  m_s1 [3];
	logic [30:0]         mm_s1;
	logic [TYPE_W-1:0]   typ_s1;
	logic                we_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1[0] <= {ref_x[31], ref_x} - {dip_x[31], dip_x};
			d_s1[1] <= {ref_y[31], ref_y} - {dip_y[31], dip_y};
			d_s1[2] <= {ref_z[31], ref_z} - {dip_z[31], dip_z};
			m_s1[0] <= mu_x;
			m_s1[1] <= mu_y;
			m_s1[2] <= mu_z;
			mm_s1   <= mu_mag;
			typ_s1  <= ({1'b0, type_index} >= (TYPE_W+1)'(NUM_TYPES)) ?
				TYPE_W'(NUM_TYPES-1) : type_index;
			we_s1   <= want_energy;
		end
	end

	// geometry products: squares, dot terms, cross terms
	logic [63:0]     pa [NPG];
	logic [63:0]     pb [NPG];
	logic [NPG-1:0]  pn;
	logic [127:0]    pg [NPG];
	logic [NPG-1:0]  pn_sd [MUL_LAT];

	always_comb begin
		for (int j = 0; j < NPG; j++) begin
			logic signed [32:0] opb;
			opb   = (j < 3) ? d_s1[OPB[j]] : {m_s1[OPB[j]][31], m_s1[OPB[j]]};
			pa[j] = mag33(d_s1[OPA[j]]);
			pb[j] = mag33(opb);
			pn[j] = d_s1[OPA[j]][32] ^ opb[32];
		end
	end

	for (genvar j = 0; j < NPG; j++) begin : g_pg
		dap_mul64 u_mul (.clk(clk), .en(en), .a(pa[j]), .b(pb[j]), .p(pg[j]));
	end

	// sums: squared distance, dot product, cross product
	logic signed [67:0] sp [NPG];
	logic [65:0]        r2_s4;
	logic signed [67:0] dot_s4;
	logic signed [67:0] c_s4 [3];

	always_comb begin
		for (int j = 0; j < NPG; j++) begin
			sp[j] = pn_sd[MUL_LAT-1][j] ? -$signed({3'b000, pg[j][64:0]})
				: $signed({3'b000, pg[j][64:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s4   <= 66'(pg[0][65:0] + pg[1][65:0] + pg[2][65:0]);
			dot_s4  <= sp[3] + sp[4] + sp[5];
			c_s4[0] <= sp[6] - sp[7];
			c_s4[1] <= sp[8] - sp[9];
			c_s4[2] <= sp[10] - sp[11];
		end
	end

	// distance
	logic [32:0] r_root;

	dap_isqrt u_sqrt (.clk(clk), .en(en), .v(r2_s4), .root(r_root));

	// r times moment magnitude
	logic [30:0]  mm_sd [L_MM];
	logic [127:0] rmu_p;
	logic [63:0]  rmu;
	logic         deg;

	dap_mul64 u_rmu (
		.clk(clk), .en(en),
		.a({31'd0, r_root}), .b({33'd0, mm_sd[L_MM-1]}), .p(rmu_p)
	);

	assign rmu = rmu_p[63:0];
	assign deg = (rmu == '0);

	// cosine: (dot << 16) / (r * mu_mag)
	logic signed [67:0] dot_sd [L_DOT];
	logic [67:0]        dot_abs;
	logic [63:0]        cos_q;
	logic               cos_ovf;
	logic               cneg_sd [DIV_LAT];

	assign dot_abs = dot_sd[L_DOT-1][67] ? $unsigned(-dot_sd[L_DOT-1])
		: $unsigned(dot_sd[L_DOT-1]);

	dap_div u_div_cos (
		.clk(clk), .en(en),
		.n({46'd0, dot_abs[65:0], 16'd0}), .d({2'b00, rmu}),
		.q(cos_q), .ovf(cos_ovf)
	);

	// deviation from rest cosine
	logic [TYPE_W-1:0]  typ_sd [L_TYP];
	logic signed [31:0] cosg;
	logic signed [32:0] dg_s104;
	logic [30:0]        k_s104;
	logic signed [32:0] dg_sd [MUL_LAT];

	assign cosg = sat32(cneg_sd[DIV_LAT-1], cos_ovf, cos_q);

	always_ff @(posedge clk) begin
		if (en) begin
			dg_s104 <= {cosg[31], cosg} - 33'(crest_q[typ_sd[L_TYP-1]]);
			k_s104  <= k_q[typ_sd[L_TYP-1]];
		end
	end

	// k times deviation
	logic [127:0] km_p;
	logic [46:0]  kmag;
	logic [63:0]  dgm;

	dap_mul64 u_kdg (
		.clk(clk), .en(en),
		.a({33'd0, k_s104}), .b(mag33(dg_s104)), .p(km_p)
	);

	assign kmag = km_p[62:16];
	assign dgm  = mag33(dg_sd[MUL_LAT-1]);

	// energy and torque numerators
	logic signed [67:0] c_sd [L_C][3];
	logic [63:0]        ca [3];
	logic [2:0]         tneg;
	logic [2:0]         tneg_sd [L_TNG];
	logic [127:0]       e_p;
	logic [127:0]       tn_p [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic [67:0] cu;
			cu      = c_sd[L_C-1][i][67] ? $unsigned(-c_sd[L_C-1][i])
				: $unsigned(c_sd[L_C-1][i]);
			ca[i]   = cu[63:0];
			tneg[i] = c_sd[L_C-1][i][67] ^ (dg_sd[MUL_LAT-1][32] && (kmag != '0));
		end
	end

	dap_mul64 u_en (.clk(clk), .en(en), .a({17'd0, kmag}), .b(dgm), .p(e_p));

	for (genvar i = 0; i < 3; i++) begin : g_tn
		dap_mul64 u_mul (
			.clk(clk), .en(en), .a(ca[i]), .b({16'd0, kmag, 1'b0}), .p(tn_p[i])
		);
	end

	// energy with saturation
	logic        we_sd [L_WE];
	logic [30:0] e_val;
	logic [30:0] e_sd [L_EN];

	assign e_val = !we_sd[L_WE-1] ? 31'd0
		: (e_p[127:47] != '0) ? 31'h7FFF_FFFF : e_p[46:16];

	// torque divide by r * mu_mag
	logic [63:0] rmu_sd [L_RMU];
	logic [63:0] tq [3];
	logic        tovf [3];

	for (genvar i = 0; i < 3; i++) begin : g_tdiv
		dap_div u_div (
			.clk(clk), .en(en), .n(tn_p[i]), .d({2'b00, rmu_sd[L_RMU-1]}),
			.q(tq[i]), .ovf(tovf[i])
		);
	end

	// signed torque saturated to 64 bits
	logic signed [63:0] t_s173 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (!tneg_sd[L_TNG-1][i]) begin
					t_s173[i] <= (tovf[i] || tq[i][63]) ? 64'h7FFF_FFFF_FFFF_FFFF : tq[i];
				end else begin
					t_s173[i] <= (tovf[i] || tq[i][63]) ? 64'h8000_0000_0000_0000
						: (~tq[i] + 64'd1);
				end
			end
		end
	end

	// force products d x T
	logic signed [32:0] d_sd [L_D][3];
	logic [63:0]        fa [NPF];
	logic [63:0]        fb [NPF];
	logic [NPF-1:0]     fn;
	logic [NPF-1:0]     fn_sd [MUL_LAT];
	logic [127:0]       fp [NPF];

	always_comb begin
		for (int j = 0; j < NPF; j++) begin
			logic [63:0] tu;
			tu    = $unsigned(t_s173[FTB[j]]);
			fa[j] = mag33(d_sd[L_D-1][FDA[j]]);
			fb[j] = t_s173[FTB[j]][63] ? (~tu + 64'd1) : tu;
			fn[j] = d_sd[L_D-1][FDA[j]][32] ^ t_s173[FTB[j]][63];
		end
	end

	for (genvar j = 0; j < NPF; j++) begin : g_fp
		dap_mul64 u_mul (.clk(clk), .en(en), .a(fa[j]), .b(fb[j]), .p(fp[j]));
	end

	// force numerators
	logic signed [99:0] sf [NPF];
	logic signed [99:0] fnum_s176 [3];

	always_comb begin
		for (int j = 0; j < NPF; j++) begin
			sf[j] = fn_sd[MUL_LAT-1][j] ? -$signed({4'd0, fp[j][95:0]})
				: $signed({4'd0, fp[j][95:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fnum_s176[0] <= sf[0] - sf[1];
			fnum_s176[1] <= sf[2] - sf[3];
			fnum_s176[2] <= sf[4] - sf[5];
		end
	end

	// force divide by r^2
	logic [65:0] r2_sd [L_R2];
	logic [99:0] fabs [3];
	logic [63:0] fq [3];
	logic        fovf [3];
	logic [2:0]  fsg_sd [DIV_LAT];

	for (genvar i = 0; i < 3; i++) begin : g_fdiv
		assign fabs[i] = fnum_s176[i][99] ? $unsigned(-fnum_s176[i])
			: $unsigned(fnum_s176[i]);

		dap_div u_div (
			.clk(clk), .en(en), .n({28'd0, fabs[i]}), .d(r2_sd[L_R2-1]),
			.q(fq[i]), .ovf(fovf[i])
		);
	end

	// side data delay lines
	logic [31:0] tc_sd [L_TC][3];
	logic        deg_sd [L_DEG];

	always_ff @(posedge clk) begin
		if (en) begin
			pn_sd[0] <= pn;
			fn_sd[0] <= fn;
			dg_sd[0] <= dg_s104;
			for (int i = 1; i < MUL_LAT; i++) begin
				pn_sd[i] <= pn_sd[i-1];
				fn_sd[i] <= fn_sd[i-1];
				dg_sd[i] <= dg_sd[i-1];
			end
			cneg_sd[0] <= dot_sd[L_DOT-1][67];
			fsg_sd[0]  <= {fnum_s176[2][99], fnum_s176[1][99], fnum_s176[0][99]};
			for (int i = 1; i < DIV_LAT; i++) begin
				cneg_sd[i] <= cneg_sd[i-1];
				fsg_sd[i]  <= fsg_sd[i-1];
			end
			mm_sd[0] <= mm_s1;
			for (int i = 1; i < L_MM; i++) mm_sd[i] <= mm_sd[i-1];
			dot_sd[0] <= dot_s4;
			for (int i = 1; i < L_DOT; i++) dot_sd[i] <= dot_sd[i-1];
			typ_sd[0] <= typ_s1;
			for (int i = 1; i < L_TYP; i++) typ_sd[i] <= typ_sd[i-1];
			c_sd[0] <= c_s4;
			for (int i = 1; i < L_C; i++) c_sd[i] <= c_sd[i-1];
			tneg_sd[0] <= tneg;
			for (int i = 1; i < L_TNG; i++) tneg_sd[i] <= tneg_sd[i-1];
			we_sd[0] <= we_s1;
			for (int i = 1; i < L_WE; i++) we_sd[i] <= we_sd[i-1];
			e_sd[0] <= e_val;
			for (int i = 1; i < L_EN; i++) e_sd[i] <= e_sd[i-1];
			rmu_sd[0] <= rmu;
			for (int i = 1; i < L_RMU; i++) rmu_sd[i] <= rmu_sd[i-1];
			d_sd[0] <= d_s1;
			for (int i = 1; i < L_D; i++) d_sd[i] <= d_sd[i-1];
			r2_sd[0] <= r2_s4;
			for (int i = 1; i < L_R2; i++) r2_sd[i] <= r2_sd[i-1];
			for (int k = 0; k < 3; k++) tc_sd[0][k] <= clamp32(t_s173[k]);
			for (int i = 1; i < L_TC; i++) tc_sd[i] <= tc_sd[i-1];
			deg_sd[0] <= deg;
			for (int i = 1; i < L_DEG; i++) deg_sd[i] <= deg_sd[i-1];
		end
	end

	// result word register
	logic [31:0] trq_s241 [3];
	logic [31:0] frc_s241 [3];
	logic [30:0] en_s241;
	logic        st_s241;

	always_ff @(posedge clk) begin
		if (en) begin
			if (deg_sd[L_DEG-1]) begin
				for (int i = 0; i < 3; i++) begin
					trq_s241[i] <= '0;
					frc_s241[i] <= '0;
				end
				en_s241 <= '0;
				st_s241 <= 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					trq_s241[i] <= tc_sd[L_TC-1][i];
					frc_s241[i] <= sat32(fsg_sd[DIV_LAT-1][i], fovf[i], fq[i]);
				end
				en_s241 <= e_sd[L_EN-1];
				st_s241 <= 1'b0;
			end
		end
	end

	assign torque_x = trq_s241[0];
	assign torque_y = trq_s241[1];
	assign torque_z = trq_s241[2];
	assign force_x  = frc_s241[0];
	assign force_y  = frc_s241[1];
	assign force_z  = frc_s241[2];
	assign energy   = en_s241;
	assign status   = st_s241;

endmodule

// ----- hw/rtl/dap_checker.sv -----
// ----------------------------------------------------------------------------
// dap_checker
// Port-level checks for the dipole angle restraint force block.
// ----------------------------------------------------------------------------
module dap_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] torque_x,
	input logic signed [31:0] torque_y,
	input logic signed [31:0] torque_z,
	input logic signed [31:0] force_x,
	input logic signed [31:0] force_y,
	input logic signed [31:0] force_z,
	input logic [30:0]        energy,
	input logic               status
);

	// a stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// a stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(torque_x) && $stable(force_x)
			&& $stable(energy) && $stable(status))
		else $error("result word changed while stalled");

	// degenerate geometry gives an all-zero result
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> torque_x == 0 && torque_y == 0 && torque_z == 0
			&& force_x == 0 && force_y == 0 && force_z == 0 && energy == 0)
		else $error("degenerate result carries nonzero fields");

	// input side stalls only behind a waiting result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no result waiting");

endmodule

bind dipole_angle_restraint_force dap_checker u_dap_checker (.*);

// ----- tb/tb_dipole_angle_restraint_force.sv -----
// ----------------------------------------------------------------------------
// tb_dipole_angle_restraint_force
// Streams restraint words through the dipole angle restraint pipeline with
// random valid gaps and output stalls, predicts each result word in Q16.16
// fixed point and checks the results in order, across several register sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dipole_angle_restraint_force;
	import dap_pkg::*;

	localparam longint unsigned MAX31 = 64'h7fff_ffff;
	localparam longint unsigned MAX63 = 64'h7fff_ffff_ffff_ffff;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 300;

	typedef logic signed [127:0] wide_t;
	typedef bit [127:0] uwide_t;

	typedef struct {
		logic signed [31:0] ref_p [3];
		logic signed [31:0] dip_p [3];
		logic signed [31:0] mu [3];
		logic [30:0]        mag;
		logic [1:0]         typ;
		logic               want_e;
	} restraint_t;

	typedef struct {
		logic signed [31:0] torque [3];
		logic signed [31:0] force_v [3];
		logic [30:0]        energy;
		logic               status;
	} torque_force_t;

	// scoreboard: register copy, pending predictions, mismatch count
	class restraint_scoreboard;
		longint unsigned k_tab [NUM_TYPES];
		longint          crest_tab [NUM_TYPES];
		torque_force_t   pending [$];
		int              errors;

		function new();
			errors = 0;
			for (int i = 0; i < NUM_TYPES; i++) begin
				k_tab[i] = 0;
				crest_tab[i] = 65536;
			end
		endfunction

		function void set_reg(int idx, logic [CFG_W-1:0] val);
			logic signed [17:0] c18;
			c18 = val[17:0];
			if (idx < NUM_TYPES) k_tab[idx] = val;
			else crest_tab[idx - NUM_TYPES] = c18;
		endfunction

		// unsigned divide, all ones on a zero divisor
		function uwide_t udiv(uwide_t n, uwide_t d);
			if (d == 0) return '1;
			return n / d;
		endfunction

		function wide_t sdiv(wide_t n, uwide_t d);
			uwide_t q;
			q = udiv(n[127] ? uwide_t'(-n) : uwide_t'(n), d);
			return n[127] ? -wide_t'(q) : wide_t'(q);
		endfunction

		function longint sat(wide_t v, longint unsigned maxpos);
			uwide_t m, mp;
			mp = maxpos;
			if (!v[127]) return (uwide_t'(v) > mp) ? longint'(maxpos) : longint'(v);
			m = -v;
			if (m > mp) return -longint'(maxpos) - 1;
			return -longint'(m);
		endfunction

		function torque_force_t predict(restraint_t it);
			torque_force_t res;
			wide_t d [3], m [3], cr [3], nf [3], r2, dot, tw [3], v;
			uwide_t cand, prod, qa, ac;
			longint unsigned r, mm, rmu, kmag, adg, cnd;
			longint cosg, dg, t [3];
			bit neg;
			for (int i = 0; i < 3; i++) begin
				d[i] = it.ref_p[i] - it.dip_p[i];
				m[i] = it.mu[i];
			end
			res.energy = '0;
			res.status = 1'b0;
			for (int i = 0; i < 3; i++) begin
				res.torque[i] = '0;
				res.force_v[i] = '0;
			end
			mm = it.mag;
			r2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
			// floor square root of the squared distance
			r = 0;
			for (int b = 33; b >= 0; b--) begin
				cnd = r | (64'd1 << b);
				cand = cnd;
				if (cand * cand <= uwide_t'(r2)) r = cnd;
			end
			if (r == 0 || mm == 0) begin
				res.status = 1'b1;
				return res;
			end
			rmu = r * mm;
			// cosine and deviation from rest
			dot = d[0] * m[0] + d[1] * m[1] + d[2] * m[2];
			cosg = sat(sdiv(dot << 16, rmu), MAX31);
			dg = cosg - crest_tab[it.typ];
			adg = (dg < 0) ? longint'(-dg) : dg;
			kmag = (k_tab[it.typ] * adg) >> 16;
			if (it.want_e) begin
				prod = kmag;
				prod = prod * adg;
				res.energy = 31'(sat(wide_t'(prod >> 16), MAX31));
			end
			// torque on the dipole
			cr[0] = d[1] * m[2] - d[2] * m[1];
			cr[1] = d[2] * m[0] - d[0] * m[2];
			cr[2] = d[0] * m[1] - d[1] * m[0];
			for (int i = 0; i < 3; i++) begin
				ac = cr[i][127] ? uwide_t'(-cr[i]) : uwide_t'(cr[i]);
				prod = ac[63:0];
				prod = prod * (2 * kmag);
				qa = udiv(prod, rmu);
				neg = cr[i][127] != (dg < 0 && kmag != 0);
				v = neg ? -wide_t'(qa) : wide_t'(qa);
				t[i] = sat(v, MAX63);
				res.torque[i] = 32'(sat(wide_t'(t[i]), MAX31));
				tw[i] = t[i];
			end
			// force couple on the reference atom
			nf[0] = d[1] * tw[2] - d[2] * tw[1];
			nf[1] = d[2] * tw[0] - d[0] * tw[2];
			nf[2] = d[0] * tw[1] - d[1] * tw[0];
			for (int i = 0; i < 3; i++)
				res.force_v[i] = 32'(sat(sdiv(nf[i], uwide_t'(r2)), MAX31));
			return res;
		endfunction

		function void note_input(restraint_t it);
			pending.push_back(predict(it));
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(torque_force_t got);
			torque_force_t exp_w;
			if (pending.size() == 0) begin
				report("result word with nothing pending");
				return;
			end
			exp_w = pending.pop_front();
			for (int i = 0; i < 3; i++) begin
				if (got.torque[i] !== exp_w.torque[i])
					report($sformatf("torque[%0d] got %0d want %0d", i, got.torque[i],
						exp_w.torque[i]));
				if (got.force_v[i] !== exp_w.force_v[i])
					report($sformatf("force[%0d] got %0d want %0d", i, got.force_v[i],
						exp_w.force_v[i]));
			end
			if (got.energy !== exp_w.energy)
				report($sformatf("energy got %0d want %0d", got.energy, exp_w.energy));
			if (got.status !== exp_w.status)
				report($sformatf("status got %0b want %0b", got.status, exp_w.status));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] ref_x = '0, ref_y = '0, ref_z = '0;
	logic signed [31:0] dip_x = '0, dip_y = '0, dip_z = '0;
	logic signed [31:0] mu_x = '0, mu_y = '0, mu_z = '0;
	logic [30:0] mu_mag = '0;
	logic [1:0] type_index = '0;
	logic want_energy = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] torque_x, torque_y, torque_z, force_x, force_y, force_z;
	logic [30:0] energy;
	logic status;

	restraint_scoreboard sb = new();
	bit no_idle = 1'b0;
	int cycle = 0;

	dipole_angle_restraint_force dut (.*);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk)
		out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 21);

	// note accepted words, check result words
	always @(posedge clk) begin
		restraint_t it;
		torque_force_t got;
		if (in_valid && !in_stall) begin
			it.ref_p = '{ref_x, ref_y, ref_z};
			it.dip_p = '{dip_x, dip_y, dip_z};
			it.mu = '{mu_x, mu_y, mu_z};
			it.mag = mu_mag;
			it.typ = type_index;
			it.want_e = want_energy;
			sb.note_input(it);
		end
		if (out_valid && !out_stall) begin
			got.torque = '{torque_x, torque_y, torque_z};
			got.force_v = '{force_x, force_y, force_z};
			got.energy = energy;
			got.status = status;
			sb.check_result(got);
		end
	end

	// called at a falling edge, returns at a falling edge
	task send_word(restraint_t it);
		while (!no_idle && $urandom_range(0, 99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		{ref_x, ref_y, ref_z} <= {it.ref_p[0], it.ref_p[1], it.ref_p[2]};
		{dip_x, dip_y, dip_z} <= {it.dip_p[0], it.dip_p[1], it.dip_p[2]};
		{mu_x, mu_y, mu_z} <= {it.mu[0], it.mu[1], it.mu[2]};
		mu_mag <= it.mag;
		type_index <= it.typ;
		want_energy <= it.want_e;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// write all force constants and rest cosines, pipeline empty
	task write_regs(longint unsigned k [NUM_TYPES], int crest [NUM_TYPES]);
		logic [CFG_W-1:0] val;
		for (int i = 0; i < 2 * NUM_TYPES; i++) begin
			if (i < NUM_TYPES) val = CFG_W'(k[i]);
			else val = CFG_W'(crest[i - NUM_TYPES]);
			cfg_we <= 1'b1;
			cfg_index <= CFG_K_TYPE0 + CFG_IDX_W'(i);
			cfg_data <= val;
			sb.set_reg(i, val);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic restraint_t make_word(logic signed [31:0] rp [3],
			logic signed [31:0] dp [3], logic signed [31:0] mv [3],
			logic [30:0] mag, logic [1:0] typ, logic we);
		restraint_t it;
		it.ref_p = rp;
		it.dip_p = dp;
		it.mu = mv;
		it.mag = mag;
		it.typ = typ;
		it.want_e = we;
		return it;
	endfunction

	// |mu| in Q16.16 from the components
	function automatic logic [30:0] mu_norm(logic signed [31:0] mv [3]);
		uwide_t s, c;
		longint unsigned r;
		s = 0;
		for (int i = 0; i < 3; i++) s += uwide_t'(wide_t'(mv[i]) * wide_t'(mv[i]));
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c <= s) r = c[63:0];
		end
		return (r > MAX31) ? 31'h7fff_ffff : r[30:0];
	endfunction

	function automatic logic signed [31:0] coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
			default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
		endcase
	endfunction

	task random_words(int count);
		restraint_t it;
		int mode, pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			mode = (pick < 15) ? 0 : $urandom_range(1, 2);
			for (int i = 0; i < 3; i++) begin
				it.ref_p[i] = coord(mode);
				it.dip_p[i] = coord(mode);
				it.mu[i] = coord(mode);
			end
			// sometimes coincident atoms
			if (pick >= 95) it.dip_p = it.ref_p;
			if (pick < 15 || pick % 7 == 0) it.mag = 31'($urandom);
			else it.mag = mu_norm(it.mu);
			if (pick == 50) it.mag = '0;
			it.typ = 2'($urandom_range(0, 3));
			it.want_e = 1'($urandom_range(0, 1));
			send_word(it);
		end
	endtask

	initial begin
		longint unsigned k_set [NUM_TYPES];
		int crest_set [NUM_TYPES];
		logic signed [31:0] z3 [3], a3 [3], b3 [3], hi3 [3], lo3 [3];
		z3 = '{0, 0, 0};
		a3 = '{32'sh0001_0000, 0, 0};
		b3 = '{0, 32'sh0001_0000, 0};
		hi3 = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
		lo3 = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values first: k zero gives zero torque and force
		send_word(make_word(a3, z3, b3, 31'h1_0000, 2'd0, 1'b1));
		drain();

		k_set = '{64'h0001_0000, 64'h0004_0000, 64'h0010_0000, 64'h7fff_ffff};
		crest_set = '{0, 32768, -65536, 65536};
		write_regs(k_set, crest_set);
		// directed words
		send_word(make_word(a3, z3, b3, 31'h1_0000, 2'd0, 1'b1));
		send_word(make_word(a3, z3, a3, 31'h1_0000, 2'd1, 1'b1));
		send_word(make_word(a3, z3, a3, 31'h1_0000, 2'd3, 1'b1));
		send_word(make_word(a3, a3, b3, 31'h1_0000, 2'd2, 1'b1));
		send_word(make_word(a3, z3, b3, 31'h0, 2'd2, 1'b1));
		send_word(make_word(a3, z3, b3, 31'h1_0000, 2'd2, 1'b0));
		send_word(make_word(a3, z3, '{32'sh0001_0000, 32'sh0001_0000, 0}, 31'h100,
			2'd3, 1'b1));
		send_word(make_word(hi3, lo3, '{32'sh7fff_ffff, 32'sh8000_0000, 0},
			31'h7fff_ffff, 2'd3, 1'b1));
		send_word(make_word(lo3, hi3, hi3, 31'h1, 2'd1, 1'b1));
		send_word(make_word(hi3, lo3, lo3, 31'h7fff_ffff, 2'd0, 1'b0));
		send_word(make_word('{0, 0, 1}, z3, '{1, 0, 0}, 31'h1, 2'd3, 1'b1));
		send_word(make_word(lo3, z3, '{32'sh8000_0000, 32'sh7fff_ffff, 5},
			31'h7fff_ffff, 2'd2, 1'b1));
		send_word(make_word(hi3, hi3, hi3, 31'h7fff_ffff, 2'd0, 1'b1));
		random_words(400);
		drain();

		k_set = '{64'h0, 64'h7fff_ffff, 64'h7fff_ffff, 64'h0000_0001};
		crest_set = '{-131072, 131071, 65536, -65536};
		write_regs(k_set, crest_set);
		random_words(350);
		drain();

		// a stretch with no idling on either side
		k_set = '{64'h0002_8000, 64'h0000_4000, 64'h0100_0000, 64'h0040_0000};
		crest_set = '{-32768, 0, 46341, -46341};
		write_regs(k_set, crest_set);
		no_idle = 1'b1;
		random_words(400);
		no_idle = 1'b0;
		drain();

		k_set = '{64'h7fff_ffff, 64'h0, 64'h0001_0000, 64'h7fff_ffff};
		crest_set = '{65536, -65536, -131072, 131071};
		write_regs(k_set, crest_set);
		random_words(480);
		drain();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d result words never arrived", sb.pending.size()));
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
